### hdl/skf_pkg.sv
`timescale 1ns / 1ps

package skf_pkg;

  // Fixed widths of the timestamp and of the process noise rate register.
  localparam int TIME_W = 32;
  localparam int RATE_W = 32;
  // Product rate * elapsed time, and the variance sum with one carry bit.
  localparam int DT_W   = RATE_W + TIME_W;
  localparam int GROW_W = DT_W + 1;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ_MUL,
    S_SQ_POST,
    S_DT_MUL,
    S_DT_POST,
    S_ORDER,
    S_PREP,
    S_GAIN_MUL,
    S_GAIN_DINIT,
    S_GAIN_DIV,
    S_GAIN_POST,
    S_VAR_MUL,
    S_VAR_DINIT,
    S_VAR_DIV,
    S_VAR_POST,
    S_ROOT_INIT,
    S_ROOT,
    S_OUT
  } skf_state_t;

endpackage

### hdl/scalar_kalman_fusion.sv
// One item at a time: in_ready is high only in idle, so a reading waits until the last result
// is handed on. A valid reading runs the stddev square, rate * elapsed time, gain multiply and
// divide, variance multiply and divide, then square root; with both variances zero the divides
// are skipped. A seeding reading runs only the square; an invalid one gives no result.
// Each step uses the shared one-bit-per-cycle add / compare-subtract unit. Reset (rst_n low at
// a clock edge) clears estimate, variance, time, rate, flags.
`timescale 1ns / 1ps

module scalar_kalman_fusion #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration port
  input  logic                              cfg_wr_en,
  input  logic [skf_pkg::RATE_W-1:0]        cfg_wr_data,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [VALUE_WIDTH-1:0]     in_measurement,
  input  logic [VALUE_WIDTH-1:0]            in_meas_stddev,
  input  logic [skf_pkg::TIME_W-1:0]        in_time_ms,
  input  logic                              in_sample_invalid,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [VALUE_WIDTH-1:0]     out_estimate,
  output logic                              out_estimate_present,
  output logic [VALUE_WIDTH-1:0]            out_estimate_stddev
);

  // Derived widths.
  localparam int V      = VALUE_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int VAR_W  = (2 * V - F > 63) ? 63 : 2 * V - F;
  localparam int DIV_W  = VAR_W + 1;
  localparam int MAG_W  = V + 1;
  localparam int ROOT_W = (VAR_W + F + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int MC_A   = (VAR_W > V) ? VAR_W : V;
  localparam int MC_W   = (MC_A > skf_pkg::RATE_W) ? MC_A : skf_pkg::RATE_W;
  localparam int MP_A   = (VAR_W > MAG_W) ? VAR_W : MAG_W;
  localparam int MP_W   = (MP_A > skf_pkg::TIME_W) ? MP_A : skf_pkg::TIME_W;
  localparam int PW     = MC_W + MP_W;
  localparam int REM_W  = (DIV_W > ROOT_W + 1) ? DIV_W : ROOT_W + 1;
  localparam int SUB_W  = REM_W + 2;
  localparam int CNT_W  = $clog2(MP_W + 1);

  // Control state.
  skf_pkg::skf_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Filter state.
  logic [skf_pkg::RATE_W-1:0] rate_r, rate_nxt;
  logic [V-1:0]               fused_value_r, fused_value_nxt;
  logic [VAR_W-1:0]           fused_var_r, fused_var_nxt;
  logic                       has_est_r, has_est_nxt;
  logic [skf_pkg::TIME_W-1:0] last_time_r, last_time_nxt;

  // Shared unit registers.
  logic [PW-1:0]    prod_r, prod_nxt;
  logic [MC_W-1:0]  mcand_r, mcand_nxt;
  logic [MP_W-1:0]  mplier_r, mplier_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;

  // Per-item working registers.
  logic [V-1:0]               meas_r, meas_nxt;
  logic [V-1:0]               sd_r, sd_nxt;
  logic [skf_pkg::TIME_W-1:0] time_r, time_nxt;
  logic                       seed_r, seed_nxt;
  logic [VAR_W-1:0]           s2_r, s2_nxt;
  logic [VAR_W-1:0]           var_r, var_nxt;
  logic [VAR_W-1:0]           v1_r, v1_nxt;
  logic [VAR_W-1:0]           v2_r, v2_nxt;
  logic [V-1:0]               mu1_r, mu1_nxt;
  logic [V-1:0]               mu2_r, mu2_nxt;
  logic [DIV_W-1:0]           sum_r, sum_nxt;
  logic                       neg_r, neg_nxt;
  logic [V-1:0]               mu_r, mu_nxt;
  logic [VAR_W-1:0]           nv_r, nv_nxt;

  // Result register.
  logic [V-1:0] out_estimate_r, out_estimate_nxt;
  logic         out_present_r, out_present_nxt;
  logic [V-1:0] out_stddev_r, out_stddev_nxt;

  // Combinational helpers.
  logic                       in_beat;
  logic                       out_free;
  logic [PW-1:0]              mul_sum;
  logic [SUB_W-1:0]           sub_a;
  logic [SUB_W-1:0]           sub_b;
  logic [SUB_W:0]             sub_full;
  logic                       sub_ge;
  logic [REM_W-1:0]           rem_step;
  logic [PW-1:0]              sq_shift;
  logic [VAR_W-1:0]           s2_sat;
  logic [skf_pkg::TIME_W-1:0] dt;
  logic [skf_pkg::GROW_W-1:0] vgrow;
  logic [VAR_W-1:0]           var_sat;
  logic                       var_first;
  logic [MAG_W-1:0]           diff;
  logic [MAG_W-1:0]           mag;
  logic [MAG_W-1:0]           mu_ext;

  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign out_valid            = out_valid_r;
  assign out_estimate         = out_estimate_r;
  assign out_estimate_present = out_present_r;
  assign out_estimate_stddev  = out_stddev_r;

  // Shared multiply step: MSB-first shift and add.
  assign mul_sum = {prod_r[PW-2:0], 1'b0}
                 + (mplier_r[MP_W-1] ? PW'(mcand_r) : '0);

  // Shared compare-subtract step, for restoring division and square root.
  always_comb begin
    if (state_r == skf_pkg::S_ROOT) begin
      sub_a = {rem_r, prod_r[PW-1:PW-2]};
      sub_b = SUB_W'({mplier_r[ROOT_W-1:0], 2'b01});
    end else begin
      sub_a = SUB_W'({rem_r, prod_r[PW-1]});
      sub_b = SUB_W'(sum_r);
    end
  end

  assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_full[SUB_W];
  assign rem_step = sub_ge ? sub_full[REM_W-1:0] : sub_a[REM_W-1:0];

  // Squared stddev, scaled and saturated to the variance width.
  assign sq_shift = prod_r >> F;
  assign s2_sat   = (|sq_shift[PW-1:VAR_W]) ? '1 : sq_shift[VAR_W-1:0];

  // Variance growth with saturation.
  assign dt      = time_r - last_time_r;
  assign vgrow   = skf_pkg::GROW_W'(fused_var_r) + skf_pkg::GROW_W'(prod_r[skf_pkg::DT_W-1:0]);
  assign var_sat = (|vgrow[skf_pkg::GROW_W-1:VAR_W]) ? '1 : vgrow[VAR_W-1:0];

  // Ordering: the stored estimate leads only with strictly smaller variance.
  assign var_first = var_r < s2_r;

  // Signed difference of the two means and its magnitude.
  assign diff = {mu2_r[V-1], mu2_r} - {mu1_r[V-1], mu1_r};
  assign mag  = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;

  // Corrected estimate, moving from mu1 toward mu2.
  assign mu_ext = neg_r ? ({mu1_r[V-1], mu1_r} - prod_r[MAG_W-1:0])
                        : ({mu1_r[V-1], mu1_r} + prod_r[MAG_W-1:0]);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      skf_pkg::S_IDLE: begin
        if (in_valid && !in_sample_invalid) state_nxt = skf_pkg::S_SQ_MUL;
      end
      skf_pkg::S_SQ_MUL: begin
        if (cnt_r == CNT_W'(1)) state_nxt = skf_pkg::S_SQ_POST;
      end
      skf_pkg::S_SQ_POST: begin
        state_nxt = has_est_r ? skf_pkg::S_DT_MUL : skf_pkg::S_OUT;
      end
      skf_pkg::S_DT_MUL: begin
        if (cnt_r == CNT_W'(1)) state_nxt = skf_pkg::S_DT_POST;
      end
      skf_pkg::S_DT_POST:  state_nxt = skf_pkg::S_ORDER;
      skf_pkg::S_ORDER:    state_nxt = skf_pkg::S_PREP;
      skf_pkg::S_PREP:     state_nxt = skf_pkg::S_GAIN_MUL;
      skf_pkg::S_GAIN_MUL: begin
        if (cnt_r == CNT_W'(1)) state_nxt = skf_pkg::S_GAIN_DINIT;
      end
      skf_pkg::S_GAIN_DINIT: begin
        state_nxt = (sum_r == '0) ? skf_pkg::S_ROOT_INIT : skf_pkg::S_GAIN_DIV;
      end
      skf_pkg::S_GAIN_DIV: begin
        if (cnt_r == CNT_W'(1)) state_nxt = skf_pkg::S_GAIN_POST;
      end
      skf_pkg::S_GAIN_POST: state_nxt = skf_pkg::S_VAR_MUL;
      skf_pkg::S_VAR_MUL: begin
        if (cnt_r == CNT_W'(1)) state_nxt = skf_pkg::S_VAR_DINIT;
      end
      skf_pkg::S_VAR_DINIT: state_nxt = skf_pkg::S_VAR_DIV;
      skf_pkg::S_VAR_DIV: begin
        if (cnt_r == CNT_W'(1)) state_nxt = skf_pkg::S_VAR_POST;
      end
      skf_pkg::S_VAR_POST:  state_nxt = skf_pkg::S_ROOT_INIT;
      skf_pkg::S_ROOT_INIT: state_nxt = skf_pkg::S_ROOT;
      skf_pkg::S_ROOT: begin
        if (cnt_r == CNT_W'(1)) state_nxt = skf_pkg::S_OUT;
      end
      skf_pkg::S_OUT: begin
        if (out_free) state_nxt = skf_pkg::S_IDLE;
      end
      default: state_nxt = skf_pkg::S_IDLE;
    endcase
  end

  // Datapath and output control per state.
  always_comb begin
    in_ready         = (state_r == skf_pkg::S_IDLE);
    cnt_nxt          = cnt_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    rate_nxt         = cfg_wr_en ? cfg_wr_data : rate_r;
    fused_value_nxt  = fused_value_r;
    fused_var_nxt    = fused_var_r;
    has_est_nxt      = has_est_r;
    last_time_nxt    = last_time_r;
    prod_nxt         = prod_r;
    mcand_nxt        = mcand_r;
    mplier_nxt       = mplier_r;
    rem_nxt          = rem_r;
    meas_nxt         = meas_r;
    sd_nxt           = sd_r;
    time_nxt         = time_r;
    seed_nxt         = seed_r;
    s2_nxt           = s2_r;
    var_nxt          = var_r;
    v1_nxt           = v1_r;
    v2_nxt           = v2_r;
    mu1_nxt          = mu1_r;
    mu2_nxt          = mu2_r;
    sum_nxt          = sum_r;
    neg_nxt          = neg_r;
    mu_nxt           = mu_r;
    nv_nxt           = nv_r;
    out_estimate_nxt = out_estimate_r;
    out_present_nxt  = out_present_r;
    out_stddev_nxt   = out_stddev_r;

    unique case (state_r)
      // Take the reading and start stddev squared.
      skf_pkg::S_IDLE: begin
        if (in_beat) begin
          meas_nxt   = in_measurement;
          sd_nxt     = in_meas_stddev;
          time_nxt   = in_time_ms;
          seed_nxt   = 1'b0;
          mcand_nxt  = MC_W'(in_meas_stddev);
          mplier_nxt = MP_W'(in_meas_stddev) << (MP_W - V);
          prod_nxt   = '0;
          cnt_nxt    = CNT_W'(V);
        end
      end
      // Iterations of the shared multiplier.
      skf_pkg::S_SQ_MUL, skf_pkg::S_DT_MUL, skf_pkg::S_GAIN_MUL, skf_pkg::S_VAR_MUL: begin
        prod_nxt   = mul_sum;
        mplier_nxt = mplier_r << 1;
        cnt_nxt    = cnt_r - CNT_W'(1);
      end
      // Seed the filter, or start rate times elapsed time.
      skf_pkg::S_SQ_POST: begin
        s2_nxt = s2_sat;
        if (has_est_r) begin
          mcand_nxt  = MC_W'(rate_r);
          mplier_nxt = MP_W'(dt) << (MP_W - skf_pkg::TIME_W);
          prod_nxt   = '0;
          cnt_nxt    = CNT_W'(skf_pkg::TIME_W);
        end else begin
          fused_value_nxt = meas_r;
          fused_var_nxt   = s2_sat;
          has_est_nxt     = 1'b1;
          seed_nxt        = 1'b1;
        end
      end
      skf_pkg::S_DT_POST: begin
        var_nxt       = var_sat;
        last_time_nxt = time_r;
      end
      skf_pkg::S_ORDER: begin
        v1_nxt  = var_first ? var_r : s2_r;
        v2_nxt  = var_first ? s2_r : var_r;
        mu1_nxt = var_first ? fused_value_r : meas_r;
        mu2_nxt = var_first ? meas_r : fused_value_r;
      end
      // Variance sum and the gain numerator v1 * |mu2 - mu1|.
      skf_pkg::S_PREP: begin
        sum_nxt    = DIV_W'(v1_r) + DIV_W'(v2_r);
        neg_nxt    = diff[MAG_W-1];
        mcand_nxt  = MC_W'(v1_r);
        mplier_nxt = MP_W'(mag) << (MP_W - MAG_W);
        prod_nxt   = '0;
        cnt_nxt    = CNT_W'(MAG_W);
      end
      // Both variances zero keeps mu1 with zero variance.
      skf_pkg::S_GAIN_DINIT: begin
        if (sum_r == '0) begin
          mu_nxt = mu1_r;
          nv_nxt = '0;
        end else begin
          rem_nxt  = REM_W'(prod_r >> MAG_W);
          prod_nxt = prod_r << (PW - MAG_W);
          cnt_nxt  = CNT_W'(MAG_W);
        end
      end
      // Iterations of the restoring divider; quotient bits enter at the bottom.
      skf_pkg::S_GAIN_DIV, skf_pkg::S_VAR_DIV: begin
        rem_nxt  = rem_step;
        prod_nxt = {prod_r[PW-2:0], sub_ge};
        cnt_nxt  = cnt_r - CNT_W'(1);
      end
      // New estimate, then start v1 * v2.
      skf_pkg::S_GAIN_POST: begin
        mu_nxt     = mu_ext[V-1:0];
        mcand_nxt  = MC_W'(v1_r);
        mplier_nxt = MP_W'(v2_r) << (MP_W - VAR_W);
        prod_nxt   = '0;
        cnt_nxt    = CNT_W'(VAR_W);
      end
      skf_pkg::S_VAR_DINIT: begin
        rem_nxt  = REM_W'(prod_r >> VAR_W);
        prod_nxt = prod_r << (PW - VAR_W);
        cnt_nxt  = CNT_W'(VAR_W);
      end
      skf_pkg::S_VAR_POST: begin
        nv_nxt = prod_r[VAR_W-1:0];
      end
      // Commit the merge and load the radicand variance * 2^F, left aligned.
      skf_pkg::S_ROOT_INIT: begin
        fused_value_nxt = mu_r;
        fused_var_nxt   = nv_r;
        prod_nxt        = PW'(RAD_W'(nv_r) << F) << (PW - RAD_W);
        rem_nxt         = '0;
        mplier_nxt      = '0;
        cnt_nxt         = CNT_W'(ROOT_W);
      end
      // Square root, one root bit per cycle, collected in the multiplier register.
      skf_pkg::S_ROOT: begin
        rem_nxt    = rem_step;
        prod_nxt   = prod_r << 2;
        mplier_nxt = {mplier_r[MP_W-2:0], sub_ge};
        cnt_nxt    = cnt_r - CNT_W'(1);
      end
      // Hand the result beat to the output register once it is free.
      skf_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_estimate_nxt = seed_r ? '0 : mu_r;
          out_present_nxt  = !seed_r;
          out_stddev_nxt   = seed_r ? sd_r : V'(mplier_r[ROOT_W-1:0]);
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  // Control and filter state, with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= skf_pkg::S_IDLE;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      rate_r        <= '0;
      fused_value_r <= '0;
      fused_var_r   <= '0;
      has_est_r     <= 1'b0;
      last_time_r   <= '0;
      seed_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
      rate_r        <= rate_nxt;
      fused_value_r <= fused_value_nxt;
      fused_var_r   <= fused_var_nxt;
      has_est_r     <= has_est_nxt;
      last_time_r   <= last_time_nxt;
      seed_r        <= seed_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    prod_r         <= prod_nxt;
    mcand_r        <= mcand_nxt;
    mplier_r       <= mplier_nxt;
    rem_r          <= rem_nxt;
    meas_r         <= meas_nxt;
    sd_r           <= sd_nxt;
    time_r         <= time_nxt;
    s2_r           <= s2_nxt;
    var_r          <= var_nxt;
    v1_r           <= v1_nxt;
    v2_r           <= v2_nxt;
    mu1_r          <= mu1_nxt;
    mu2_r          <= mu2_nxt;
    sum_r          <= sum_nxt;
    neg_r          <= neg_nxt;
    mu_r           <= mu_nxt;
    nv_r           <= nv_nxt;
    out_estimate_r <= out_estimate_nxt;
    out_present_r  <= out_present_nxt;
    out_stddev_r   <= out_stddev_nxt;
  end

`ifndef NO_ASSERTIONS
  // A dropped reading leaves the filter untouched and the block idle.
  a_drop_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_sample_invalid) |=>
      (state_r == skf_pkg::S_IDLE && $stable(fused_value_r) && $stable(fused_var_r)
       && $stable(has_est_r)))
    else $error("invalid reading changed the filter state");

  // The divider remainder always stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skf_pkg::S_GAIN_DIV || state_r == skf_pkg::S_VAR_DIV) |-> (rem_r < sum_r))
    else $error("divider remainder not below divisor");

  // The merged estimate lies between the two means.
  a_mu_between: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skf_pkg::S_VAR_MUL) |->
      (($signed(mu_r) >= $signed(mu1_r) && $signed(mu_r) <= $signed(mu2_r))
       || ($signed(mu_r) <= $signed(mu1_r) && $signed(mu_r) >= $signed(mu2_r))))
    else $error("merged estimate outside the two means");

  // Iterating states never run with an exhausted counter.
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skf_pkg::S_SQ_MUL || state_r == skf_pkg::S_DT_MUL
     || state_r == skf_pkg::S_GAIN_MUL || state_r == skf_pkg::S_VAR_MUL
     || state_r == skf_pkg::S_GAIN_DIV || state_r == skf_pkg::S_VAR_DIV
     || state_r == skf_pkg::S_ROOT) |-> (cnt_r != '0))
    else $error("iteration counter exhausted inside an iterating state");
`endif

endmodule

### tb/scalar_kalman_fusion_tb.sv
`timescale 1ns / 1ps

module scalar_kalman_fusion_tb;

  localparam int TIME_W      = skf_pkg::TIME_W;
  localparam int RATE_W      = skf_pkg::RATE_W;
  localparam int FRAC        = 16;
  localparam int VW          = 32;
  localparam int VAR_W       = 2 * VW - FRAC;
  localparam logic [VAR_W-1:0] VAR_MAX = '1;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int PHASES      = 8;
  localparam int PER_PHASE   = 104;

  typedef struct {
    logic signed [VW-1:0] measurement;
    logic [VW-1:0]        meas_stddev;
    logic [TIME_W-1:0]    time_ms;
    logic                 sample_invalid;
  } reading_t;

  typedef struct {
    logic signed [VW-1:0] estimate;
    logic                 present;
    logic [VW-1:0]        stddev;
  } fusion_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [RATE_W-1:0]        cfg_wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [VW-1:0]     in_measurement = '0;
  logic [VW-1:0]            in_meas_stddev = '0;
  logic [TIME_W-1:0]        in_time_ms = '0;
  logic                     in_sample_invalid = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [VW-1:0]     out_estimate;
  logic                     out_estimate_present;
  logic [VW-1:0]            out_estimate_stddev;

  // Predicted filter state, kept in step with every accepted reading.
  logic signed [VW-1:0]     fused_mean = '0;
  logic [VAR_W-1:0]         fused_var = '0;
  bit                       have_estimate = 1'b0;
  logic [TIME_W-1:0]        last_stamp = '0;
  logic [RATE_W-1:0]        noise_rate = '0;

  reading_t                 pending_readings[$];
  fusion_t                  expected_fusions[$];
  reading_t                 next_reading;
  reading_t                 sampled_reading;
  fusion_t                  predicted_fusion;
  fusion_t                  wanted_fusion;

  int                       in_driven = 0;
  int                       in_taken = 0;
  int                       ignored_count = 0;
  int                       results_checked = 0;
  int                       fail_count = 0;
  int                       rate_settings = 0;
  int                       cycle_count = 0;
  int                       burst_left = 0;
  int                       gap_left = 0;
  bit                       sender_steady = 1'b1;
  bit                       receiver_steady = 1'b1;
  logic [15:0]              stall_pattern = 16'hFFFF;
  logic [6:0]               rx_step = '0;
  logic [TIME_W-1:0]        stamp_cursor = '0;

  scalar_kalman_fusion DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_measurement      (in_measurement),
    .in_meas_stddev      (in_meas_stddev),
    .in_time_ms          (in_time_ms),
    .in_sample_invalid   (in_sample_invalid),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_estimate        (out_estimate),
    .out_estimate_present(out_estimate_present),
    .out_estimate_stddev (out_estimate_stddev)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Integer square root of a variance scaled up by the fraction bits.
  function automatic logic [VW-1:0] variance_root(input logic [VAR_W-1:0] v);
    logic [63:0]   scaled;
    logic [VW-1:0] root;
    logic [VW-1:0] trial;
    scaled = {v, {FRAC{1'b0}}};
    root = '0;
    for (int b = VW - 1; b >= 0; b--) begin
      trial = root | (VW'(1) << b);
      if (64'(trial) * 64'(trial) <= scaled) root = trial;
    end
    return root;
  endfunction

  // Fuses one reading into the predicted state; returns 1 when a result is due.
  function automatic bit fuse_reading(input reading_t r, output fusion_t res);
    logic [63:0]          sq;
    logic [VAR_W-1:0]     meas_var;
    logic [VAR_W-1:0]     grown_var;
    logic [VAR_W-1:0]     v1;
    logic [VAR_W-1:0]     v2;
    logic [VAR_W-1:0]     new_var;
    logic [TIME_W-1:0]    dt;
    logic [64:0]          grown_sum;
    logic [VAR_W:0]       var_sum;
    logic signed [33:0]   mu1;
    logic signed [33:0]   mu2;
    logic signed [33:0]   diff;
    logic signed [33:0]   step;
    logic signed [33:0]   new_mu;
    logic [33:0]          mag;
    logic [127:0]         quot;
    bit                   stored_first;
    res.estimate = '0;
    res.present = 1'b0;
    res.stddev = '0;
    if (r.sample_invalid) return 1'b0;

    sq = (64'(r.meas_stddev) * 64'(r.meas_stddev)) >> FRAC;
    meas_var = (sq > 64'(VAR_MAX)) ? VAR_MAX : sq[VAR_W-1:0];

    // The first valid reading seeds the estimate and leaves the stored time alone.
    if (!have_estimate) begin
      fused_mean = r.measurement;
      fused_var = meas_var;
      have_estimate = 1'b1;
      res.stddev = r.meas_stddev;
      return 1'b1;
    end

    // Grow the variance by the process noise over the elapsed time, saturating.
    dt = r.time_ms - last_stamp;
    grown_sum = 65'(fused_var) + 65'(noise_rate) * 65'(dt);
    grown_var = (grown_sum > 65'(VAR_MAX)) ? VAR_MAX : grown_sum[VAR_W-1:0];
    last_stamp = r.time_ms;

    // The stored estimate leads only when its variance is strictly smaller.
    stored_first = grown_var < meas_var;
    mu1 = stored_first ? fused_mean : r.measurement;
    mu2 = stored_first ? r.measurement : fused_mean;
    v1 = stored_first ? grown_var : meas_var;
    v2 = stored_first ? meas_var : grown_var;
    var_sum = v1 + v2;

    if (var_sum == '0) begin
      new_mu = mu1;
      new_var = '0;
    end else begin
      diff = mu2 - mu1;
      mag = (diff < 0) ? -diff : diff;
      quot = (128'(v1) * 128'(mag)) / 128'(var_sum);
      step = quot[33:0];
      new_mu = (diff < 0) ? mu1 - step : mu1 + step;
      quot = (128'(v1) * 128'(v2)) / 128'(var_sum);
      new_var = quot[VAR_W-1:0];
    end

    fused_mean = new_mu[VW-1:0];
    fused_var = new_var;
    res.estimate = new_mu[VW-1:0];
    res.present = 1'b1;
    res.stddev = variance_root(new_var);
    return 1'b1;
  endfunction

  // Sender: bursts of beats separated by random gaps, or by none in steady phases.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_taken != in_driven) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_readings.size() > 0) begin
      next_reading = pending_readings.pop_front();
      in_valid <= 1'b1;
      in_measurement <= next_reading.measurement;
      in_meas_stddev <= next_reading.meas_stddev;
      in_time_ms <= next_reading.time_ms;
      in_sample_invalid <= next_reading.sample_invalid;
      in_driven <= in_driven + 1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 8);
        if (sender_steady) begin
          gap_left <= 0;
        end else if ($urandom_range(0, 4) == 0) begin
          gap_left <= $urandom_range(20, 350);
        end else begin
          gap_left <= $urandom_range(0, 20);
        end
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: ready follows a rotating stall pattern, or stays high.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (receiver_steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= stall_pattern[rx_step[6:3]];
      rx_step <= rx_step + 1'b1;
    end
  end

  // Monitor: predict on every input beat, check every result beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_taken <= in_taken + 1;
        sampled_reading.measurement = in_measurement;
        sampled_reading.meas_stddev = in_meas_stddev;
        sampled_reading.time_ms = in_time_ms;
        sampled_reading.sample_invalid = in_sample_invalid;
        if (fuse_reading(sampled_reading, predicted_fusion)) begin
          expected_fusions.push_back(predicted_fusion);
        end else begin
          ignored_count++;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_fusions.size() == 0) begin
          $error("result beat with no reading pending: estimate %0d stddev %0d",
                 out_estimate, out_estimate_stddev);
          fail_count++;
        end else begin
          wanted_fusion = expected_fusions.pop_front();
          results_checked++;
          if (out_estimate !== wanted_fusion.estimate) begin
            $error("estimate: expected %0d, got %0d", wanted_fusion.estimate, out_estimate);
            fail_count++;
          end
          if (out_estimate_present !== wanted_fusion.present) begin
            $error("estimate_present: expected %0d, got %0d",
                   wanted_fusion.present, out_estimate_present);
            fail_count++;
          end
          if (out_estimate_stddev !== wanted_fusion.stddev) begin
            $error("estimate_stddev: expected %0d, got %0d",
                   wanted_fusion.stddev, out_estimate_stddev);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, expected_fusions.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_reading(input logic [VW-1:0] meas, input logic [VW-1:0] sd,
                              input logic [TIME_W-1:0] stamp, input logic invalid);
    reading_t r;
    r.measurement = meas;
    r.meas_stddev = sd;
    r.time_ms = stamp;
    r.sample_invalid = invalid;
    pending_readings.push_back(r);
  endtask

  // Waits until every reading is taken and every result has arrived.
  // The check runs on the rising edge, where the sender's counters are settled.
  task automatic wait_until_drained();
    while (pending_readings.size() != 0 || in_taken != in_driven ||
           expected_fusions.size() != 0) begin
      @(posedge clk);
    end
    // Let an ignored reading clear the block before moving on.
    repeat (20) @(negedge clk);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] rate);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= rate;
    noise_rate = rate;
    rate_settings++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic reading_t random_reading();
    reading_t r;
    if ($urandom_range(0, 3) == 0) begin
      r.measurement = $urandom;
    end else begin
      r.measurement = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
    end
    case ($urandom_range(0, 9))
      0:       r.meas_stddev = '0;
      1:       r.meas_stddev = '1;
      2, 3:    r.meas_stddev = $urandom;
      4:       r.meas_stddev = $urandom_range(1, 32'h0000_0100);
      default: r.meas_stddev = $urandom_range(1, 32'h0040_0000);
    endcase
    if ($urandom_range(0, 9) == 0) begin
      r.time_ms = $urandom;
    end else begin
      r.time_ms = stamp_cursor + $urandom_range(0, 2000);
    end
    stamp_cursor = r.time_ms;
    r.sample_invalid = ($urandom_range(0, 9) == 0);
    return r;
  endfunction

  initial begin
    reading_t r;
    int phase_pushed;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: no process noise, seeding, ties, zero variances, extremes.
    write_rate('0);
    push_reading(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_reading(32'h7FFF_FFFF, 32'h0001_0000, 32'd1000, 1'b0);
    push_reading(32'h8000_0000, 32'h0001_0000, 32'd0, 1'b0);
    push_reading(32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    push_reading(32'h0000_0000, 32'h0000_0000, 32'd5, 1'b0);
    push_reading(32'h1234_5678, 32'h0000_0000, 32'd6, 1'b0);
    push_reading(32'hFFFF_FFFF, 32'h0000_0001, 32'd7, 1'b0);
    push_reading(32'h4000_0000, 32'hFFFF_FFFF, 32'd8, 1'b0);
    push_reading(32'h8000_0000, 32'hFFFF_FFFF, 32'd9, 1'b0);
    wait_until_drained();

    // Directed: maximum noise rate saturates the grown variance.
    write_rate('1);
    push_reading(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_reading(32'h8000_0000, 32'h0000_8000, 32'd0, 1'b0);
    push_reading(32'h0000_0005, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b0);
    push_reading(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    push_reading(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0005, 1'b0);
    push_reading(32'h8000_0001, 32'h0000_0001, 32'h0000_0005, 1'b0);
    wait_until_drained();

    // Directed: smallest nonzero rate with a wrapping timestamp.
    write_rate(32'd1);
    push_reading(32'h0001_0000, 32'h0000_4000, 32'hFFFF_FF00, 1'b0);
    push_reading(32'hFFFF_0000, 32'h0002_0000, 32'h0000_0010, 1'b0);
    push_reading(32'h0000_0100, 32'h0000_0100, 32'h0000_0010, 1'b0);
    push_reading(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    wait_until_drained();
    stamp_cursor = last_stamp;

    // Random phases, each under its own rate and idling mix.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: write_rate($urandom_range(0, 32'h0000_0400));
        1: write_rate($urandom);
        2: write_rate((p == 2) ? '0 : $urandom_range(0, 32'h0002_0000));
        default: write_rate((p == 3) ? '1 : $urandom_range(0, 32'h0000_0040));
      endcase
      sender_steady = (p % 3 == 0);
      receiver_steady = (p % 4 == 1);
      stall_pattern = $urandom | 16'h0001;
      phase_pushed = 0;
      while (phase_pushed < PER_PHASE) begin
        r = random_reading();
        pending_readings.push_back(r);
        phase_pushed++;
      end
      wait_until_drained();
    end

    repeat (300) @(negedge clk);
    $display("Sent %0d readings (%0d ignored as invalid) under %0d noise rate settings.",
             in_taken, ignored_count, rate_settings);
    $display("Checked %0d fused results, %0d field errors.", results_checked, fail_count);
    if (fail_count == 0 && expected_fusions.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### scalar_kalman_fusion.f
hdl/skf_pkg.sv
hdl/scalar_kalman_fusion.sv
tb/scalar_kalman_fusion_tb.sv
